// ----- hdl/sr2_pkg.sv -----
package sr2_pkg;

    localparam int DATA_W = 32;
    localparam int COEF_W = 32;
    localparam int C_FRAC = COEF_W - 2;
    localparam int NPROD  = 6;

    // rounded first products, first-level sums, rounded second products, final sums
    localparam int T0_W = DATA_W + 2;
    localparam int T_W  = DATA_W + 3;
    localparam int P_W  = T_W + 2;
    localparam int S_W  = P_W + 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic signed [DATA_W-1:0] z_in;
        logic signed [COEF_W-1:0] cosine;
        logic signed [COEF_W-1:0] sine;
        logic                     last_in;
    } t_sr2_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic signed [DATA_W-1:0] z_out;
        logic                     clipped;
        logic                     last_out;
    } t_sr2_out;

    typedef struct packed {
        logic signed [COEF_W-1:0] cosine;
        logic signed [COEF_W-1:0] sine;
        logic                     last;
    } t_sr2_side;

    localparam int SIDE_W = $bits(t_sr2_side);

endpackage

// ----- hdl/symmetric_2x2_rotation_apply.sv -----
// Applies a plane rotation from both sides to a symmetric 2x2 matrix [[x,z],[z,y]]
// (Q15.16 entries, Q1.30 cosine and sine) and returns the rotated x, y and z, each
// rounded per product (ties away from zero) and saturated to Q15.16, with a clip
// flag and the last marker carried alongside. One matrix is taken every cycle while
// o_stall is low. The path runs through two banks of six multipliers, each a
// multiply stage and a rounding stage, with one add stage between them and an
// add-and-saturate output register after them. Empty stages fill while the output
// is stalled, so the input stalls only once all six stages hold a beat.
module symmetric_2x2_rotation_apply (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  sr2_pkg::t_sr2_in i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output sr2_pkg::t_sr2_out o_data
);
    import sr2_pkg::*;

    logic signed [DATA_W-1:0] w_a1 [NPROD];
    logic signed [COEF_W-1:0] w_b1 [NPROD];
    t_sr2_side                w_side0;
    logic signed [T0_W-1:0]   w_r1 [NPROD];
    t_sr2_side                w_side1;
    logic                     w_v1, w_st1;

    logic signed [T_W-1:0]    w_t3, w_t4, w_t5, w_t6;
    t_sr2_side                w_side2;
    logic                     w_v2, w_st2;

    logic signed [T_W-1:0]    w_a2 [NPROD];
    logic signed [COEF_W-1:0] w_b2 [NPROD];
    logic signed [P_W-1:0]    w_r2 [NPROD];
    logic                     w_last3;
    logic                     w_v3, w_st3;

    always_comb begin
        w_side0.cosine = i_data.cosine;
        w_side0.sine   = i_data.sine;
        w_side0.last   = i_data.last_in;

        w_a1[0] = i_data.z_in;  w_b1[0] = i_data.sine;
        w_a1[1] = i_data.z_in;  w_b1[1] = i_data.cosine;
        w_a1[2] = i_data.x_in;  w_b1[2] = i_data.sine;
        w_a1[3] = i_data.y_in;  w_b1[3] = i_data.sine;
        w_a1[4] = i_data.x_in;  w_b1[4] = i_data.cosine;
        w_a1[5] = i_data.y_in;  w_b1[5] = i_data.cosine;

        w_a2[0] = w_t5;  w_b2[0] = w_side2.cosine;
        w_a2[1] = w_t4;  w_b2[1] = w_side2.sine;
        w_a2[2] = w_t6;  w_b2[2] = w_side2.cosine;
        w_a2[3] = w_t3;  w_b2[3] = w_side2.sine;
        w_a2[4] = w_t4;  w_b2[4] = w_side2.cosine;
        w_a2[5] = w_t5;  w_b2[5] = w_side2.sine;
    end

    sr2_mulrnd #(
        .AW (DATA_W),
        .BW (COEF_W),
        .F  (C_FRAC),
        .SW (SIDE_W)
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_a     (w_a1),
        .i_b     (w_b1),
        .i_side  (w_side0),
        .o_valid (w_v1),
        .i_stall (w_st1),
        .o_r     (w_r1),
        .o_side  (w_side1)
    );

    sr2_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_stall (w_st1),
        .i_r     (w_r1),
        .i_side  (w_side1),
        .o_valid (w_v2),
        .i_stall (w_st2),
        .o_t3    (w_t3),
        .o_t4    (w_t4),
        .o_t5    (w_t5),
        .o_t6    (w_t6),
        .o_side  (w_side2)
    );

    sr2_mulrnd #(
        .AW (T_W),
        .BW (COEF_W),
        .F  (C_FRAC),
        .SW (1)
    ) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_stall (w_st2),
        .i_a     (w_a2),
        .i_b     (w_b2),
        .i_side  (w_side2.last),
        .o_valid (w_v3),
        .i_stall (w_st3),
        .o_r     (w_r2),
        .o_side  (w_last3)
    );

    sr2_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_stall (w_st3),
        .i_r     (w_r2),
        .i_last  (w_last3),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side can move");

endmodule

// ----- hdl/sr2_mulrnd.sv -----
module sr2_mulrnd #(
    parameter int AW = sr2_pkg::DATA_W,
    parameter int BW = sr2_pkg::COEF_W,
    parameter int F  = sr2_pkg::C_FRAC,
    parameter int SW = sr2_pkg::SIDE_W,
    localparam int RW = AW + BW - F
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [AW-1:0] i_a [sr2_pkg::NPROD],
    input  logic signed [BW-1:0] i_b [sr2_pkg::NPROD],
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [RW-1:0] o_r [sr2_pkg::NPROD],
    output logic [SW-1:0]        o_side
);
    import sr2_pkg::*;

    localparam int PW = AW + BW;
    localparam logic signed [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_p [NPROD];
    logic signed [RW-1:0] r_r [NPROD];
    logic [SW-1:0]        r_s1, r_s2;

    logic signed [PW-1:0] n_p   [NPROD];
    logic signed [PW-1:0] n_sum [NPROD];
    logic signed [PW-1:0] n_sh  [NPROD];
    logic signed [RW-1:0] n_r   [NPROD];
    logic                 stall1, stall2;

    assign stall2  = r_v2 && i_stall;
    assign stall1  = r_v1 && stall2;
    assign o_stall = stall1;
    assign o_valid = r_v2;
    assign o_r     = r_r;
    assign o_side  = r_s2;

    // round half away from zero: add half, less one for a negative product
    always_comb begin
        for (int k = 0; k < NPROD; k++) begin
            n_p[k]   = PW'(i_a[k]) * PW'(i_b[k]);
            n_sum[k] = r_p[k] + HALF - $signed({{(PW-1){1'b0}}, r_p[k][PW-1]});
            n_sh[k]  = n_sum[k] >>> F;
            n_r[k]   = n_sh[k][RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (!stall1) begin
                r_v1 <= i_valid;
            end
            if (!stall2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall1 && i_valid) begin
            r_p  <= n_p;
            r_s1 <= i_side;
        end
        if (!stall2 && r_v1) begin
            r_r  <= n_r;
            r_s2 <= r_s1;
        end
    end

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !i_stall |=> r_v2)
        else $error("product stage did not advance into rounding stage");

endmodule

// ----- hdl/sr2_mix.sv -----
module sr2_mix (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [sr2_pkg::T0_W-1:0] i_r [sr2_pkg::NPROD],
    input  sr2_pkg::t_sr2_side             i_side,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [sr2_pkg::T_W-1:0] o_t3,
    output logic signed [sr2_pkg::T_W-1:0] o_t4,
    output logic signed [sr2_pkg::T_W-1:0] o_t5,
    output logic signed [sr2_pkg::T_W-1:0] o_t6,
    output sr2_pkg::t_sr2_side             o_side
);
    import sr2_pkg::*;

    logic                  r_v;
    logic signed [T_W-1:0] r_t3, r_t4, r_t5, r_t6;
    t_sr2_side             r_side;

    logic signed [T_W-1:0] n_t3, n_t4, n_t5, n_t6;
    logic                  stall;

    // products in order: s*z, c*z, s*x, s*y, c*x, c*y
    always_comb begin
        n_t3 = T_W'(i_r[1]) - T_W'(i_r[2]);
        n_t4 = T_W'(i_r[1]) + T_W'(i_r[3]);
        n_t5 = T_W'(i_r[4]) + T_W'(i_r[0]);
        n_t6 = T_W'(i_r[5]) - T_W'(i_r[0]);
    end

    assign stall   = r_v && i_stall;
    assign o_stall = stall;
    assign o_valid = r_v;
    assign o_t3    = r_t3;
    assign o_t4    = r_t4;
    assign o_t5    = r_t5;
    assign o_t6    = r_t6;
    assign o_side  = r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && i_valid) begin
            r_t3   <= n_t3;
            r_t4   <= n_t4;
            r_t5   <= n_t5;
            r_t6   <= n_t6;
            r_side <= i_side;
        end
    end

endmodule

// ----- hdl/sr2_sat.sv -----
module sr2_sat (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [sr2_pkg::P_W-1:0] i_r [sr2_pkg::NPROD],
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output sr2_pkg::t_sr2_out              o_data
);
    import sr2_pkg::*;

    localparam logic signed [S_W-1:0] SMAX = {{(S_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [S_W-1:0] SMIN = {{(S_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0]     DMAX = SMAX[DATA_W-1:0];
    localparam logic [DATA_W-1:0]     DMIN = SMIN[DATA_W-1:0];

    function automatic logic [DATA_W:0] f_sat(input logic signed [S_W-1:0] v);
        if (v > SMAX) begin
            return {1'b1, DMAX};
        end else if (v < SMIN) begin
            return {1'b1, DMIN};
        end
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    logic                  r_v;
    t_sr2_out              r_q;

    logic signed [S_W-1:0] n_x, n_y, n_z;
    logic [DATA_W:0]       n_sx, n_sy, n_sz;
    t_sr2_out              n_q;
    logic                  stall;

    // products in order: c*t5, s*t4, c*t6, s*t3, c*t4, s*t5
    always_comb begin
        n_x  = S_W'(i_r[0]) + S_W'(i_r[1]);
        n_y  = S_W'(i_r[2]) - S_W'(i_r[3]);
        n_z  = S_W'(i_r[4]) - S_W'(i_r[5]);
        n_sx = f_sat(n_x);
        n_sy = f_sat(n_y);
        n_sz = f_sat(n_z);
        n_q.x_out    = n_sx[DATA_W-1:0];
        n_q.y_out    = n_sy[DATA_W-1:0];
        n_q.z_out    = n_sz[DATA_W-1:0];
        n_q.clipped  = n_sx[DATA_W] | n_sy[DATA_W] | n_sz[DATA_W];
        n_q.last_out = i_last;
    end

    assign stall   = r_v && i_stall;
    assign o_stall = stall;
    assign o_valid = r_v;
    assign o_data  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && i_valid) begin
            r_q <= n_q;
        end
    end

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_q.clipped |->
            (r_q.x_out == DMAX || r_q.x_out == DMIN || r_q.y_out == DMAX ||
             r_q.y_out == DMIN || r_q.z_out == DMAX || r_q.z_out == DMIN))
        else $error("clip flag set with no result at a rail");

endmodule

// ----- dv/symmetric_2x2_rotation_apply_test.sv -----
module symmetric_2x2_rotation_apply_test;

    import sr2_pkg::*;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SOME, IDLE_OFTEN} t_idle_mode;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic signed [DATA_W-1:0] D_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] D_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] C_ONE  = 1 <<< C_FRAC;
    localparam logic signed [COEF_W-1:0] C_HALF = 1 <<< (C_FRAC - 1);
    localparam logic signed [COEF_W-1:0] C_R2   = 32'sh2D41_3CCD;
    localparam logic signed [COEF_W-1:0] C_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] C_MIN  = {1'b1, {(COEF_W-1){1'b0}}};

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_sr2_in   i_data;
    logic      o_valid;
    logic      i_stall;
    t_sr2_out  o_data;

    t_sr2_out   rotated_q[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    t_idle_mode src_idle;
    t_idle_mode snk_idle;

    symmetric_2x2_rotation_apply u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // round(a * b / 2^C_FRAC), ties away from zero
    function automatic logic signed [127:0] mul_round(input logic signed [127:0] a,
                                                      input logic signed [127:0] b);
        logic         neg;
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] q;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        q   = (ua * ub + (128'd1 << (C_FRAC - 1))) >> C_FRAC;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic data_overflows(input logic signed [127:0] v);
        return (v > $signed({{(128-DATA_W){1'b0}}, D_MAX})) ||
               (v < $signed({{(128-DATA_W){1'b1}}, D_MIN}));
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_data(input logic signed [127:0] v);
        if (v > $signed({{(128-DATA_W){1'b0}}, D_MAX})) begin
            return D_MAX;
        end
        if (v < $signed({{(128-DATA_W){1'b1}}, D_MIN})) begin
            return D_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic t_sr2_out rotate_matrix(input t_sr2_in m);
        logic signed [127:0] x, y, z, c, s;
        logic signed [127:0] t1, t2, t3, t4, t5, t6;
        logic signed [127:0] rx, ry, rz;
        t_sr2_out            r;
        x  = $signed(m.x_in);
        y  = $signed(m.y_in);
        z  = $signed(m.z_in);
        c  = $signed(m.cosine);
        s  = $signed(m.sine);
        t1 = mul_round(s, z);
        t2 = mul_round(c, z);
        t3 = t2 - mul_round(s, x);
        t4 = t2 + mul_round(s, y);
        t5 = mul_round(c, x) + t1;
        t6 = mul_round(c, y) - t1;
        rx = mul_round(c, t5) + mul_round(s, t4);
        ry = mul_round(c, t6) - mul_round(s, t3);
        rz = mul_round(c, t4) - mul_round(s, t5);
        r.x_out    = clamp_data(rx);
        r.y_out    = clamp_data(ry);
        r.z_out    = clamp_data(rz);
        r.clipped  = data_overflows(rx) | data_overflows(ry) | data_overflows(rz);
        r.last_out = m.last_in;
        return r;
    endfunction

    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                return 0;
            end
            IDLE_SOME: begin
                return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
            end
            default: begin
                return $urandom_range(0, 17);
            end
        endcase
    endfunction

    function automatic t_sr2_in make_matrix(input logic signed [DATA_W-1:0] x,
                                            input logic signed [DATA_W-1:0] y,
                                            input logic signed [DATA_W-1:0] z,
                                            input logic signed [COEF_W-1:0] c,
                                            input logic signed [COEF_W-1:0] s,
                                            input logic last);
        t_sr2_in m;
        m.x_in    = x;
        m.y_in    = y;
        m.z_in    = z;
        m.cosine  = c;
        m.sine    = s;
        m.last_in = last;
        return m;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_entry();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0: begin
                v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            end
            1, 2: begin
                v = $urandom;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: v = D_MAX;
                    1: v = D_MIN;
                    2: v = '0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: begin
                v = $signed($urandom) >>> $urandom_range(0, 16);
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        longint v;
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        v = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
        return v[COEF_W-1:0];
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    task automatic send_matrix(input t_sr2_in m);
        int gap;
        gap = draw_wait(src_idle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rotated_q.push_back(rotate_matrix(m));
    endtask

    task automatic test_extremes();
        src_idle = IDLE_NONE;
        snk_idle = IDLE_NONE;
        send_matrix(make_matrix(D_MAX, D_MIN, '0, C_ONE, '0, 1'b0));
        send_matrix(make_matrix(D_MIN, D_MAX, D_MAX, C_ONE, '0, 1'b1));
        send_matrix(make_matrix(D_MAX, D_MIN, D_MIN, '0, C_ONE, 1'b0));
        send_matrix(make_matrix(D_MAX, D_MAX, D_MAX, -C_ONE, '0, 1'b1));
        send_matrix(make_matrix(D_MIN, D_MIN, D_MIN, '0, -C_ONE, 1'b0));
        send_matrix(make_matrix(D_MAX, D_MIN, D_MAX, C_R2, C_R2, 1'b1));
        send_matrix(make_matrix(D_MIN, D_MAX, D_MIN, C_R2, -C_R2, 1'b0));
        send_matrix(make_matrix(D_MAX, D_MAX, D_MIN, C_ONE, C_ONE, 1'b1));
        send_matrix(make_matrix('0, '0, '0, '0, '0, 1'b1));
        send_matrix(make_matrix(-1, 1, -1, C_ONE, -C_ONE, 1'b0));
        send_matrix(make_matrix(D_MIN, D_MIN, D_MIN, -C_ONE, -C_ONE, 1'b1));
    endtask

    task automatic test_rounding_ties();
        snk_idle = IDLE_OFTEN;
        send_matrix(make_matrix(1, -1, 3, C_HALF, C_HALF, 1'b0));
        send_matrix(make_matrix(-1, 1, -3, C_HALF, -C_HALF, 1'b1));
        send_matrix(make_matrix(3, 5, -7, -C_HALF, C_HALF, 1'b0));
        send_matrix(make_matrix(32'sh0001_0001, 1, 1, 32'sh1000_0000, 32'sh3000_0000, 1'b1));
    endtask

    task automatic test_out_of_range_coefs();
        src_idle = IDLE_OFTEN;
        send_matrix(make_matrix(D_MAX, D_MIN, 1, C_MAX, C_MIN, 1'b0));
        send_matrix(make_matrix(D_MIN, D_MIN, D_MAX, C_MIN, C_MIN, 1'b1));
        send_matrix(make_matrix(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000,
                                32'sh6000_0000, -32'sh5000_0000, 1'b0));
        send_matrix(make_matrix(12345, -678, 910, C_MAX, C_MAX, 1'b1));
    endtask

    task automatic test_random_rotations(input int count);
        real                      angle;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] s;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                src_idle = t_idle_mode'($urandom_range(0, 2));
                snk_idle = t_idle_mode'($urandom_range(0, 2));
            end
            angle = $urandom_range(0, 1000000) * 6.283185307179586 / 1000000.0;
            c     = $rtoi($cos(angle) * 1073741824.0);
            s     = $rtoi($sin(angle) * 1073741824.0);
            send_matrix(make_matrix(rand_entry(), rand_entry(), rand_entry(), c, s,
                                    1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_random_coefs(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 80 == 0) begin
                src_idle = t_idle_mode'($urandom_range(0, 2));
                snk_idle = t_idle_mode'($urandom_range(0, 2));
            end
            send_matrix(make_matrix(rand_entry(), rand_entry(), rand_entry(),
                                    rand_coef(), rand_coef(), 1'($urandom_range(0, 1))));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (rotated_q.size() == 0) begin
                report_mismatch("unexpected beat x_out", o_data.x_out, 0);
            end else begin
                t_sr2_out want;
                want = rotated_q.pop_front();
                if (o_data.x_out !== want.x_out) begin
                    report_mismatch("x_out", o_data.x_out, want.x_out);
                end
                if (o_data.y_out !== want.y_out) begin
                    report_mismatch("y_out", o_data.y_out, want.y_out);
                end
                if (o_data.z_out !== want.z_out) begin
                    report_mismatch("z_out", o_data.z_out, want.z_out);
                end
                if (o_data.clipped !== want.clipped) begin
                    report_mismatch("clipped", o_data.clipped, want.clipped);
                end
                if (o_data.last_out !== want.last_out) begin
                    report_mismatch("last_out", o_data.last_out, want.last_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = draw_wait(snk_idle);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        src_idle    = IDLE_NONE;
        snk_idle    = IDLE_NONE;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_rounding_ties();
        test_out_of_range_coefs();
        test_random_rotations(600);
        test_random_coefs(250);
        i_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sr2_pkg.sv
hdl/sr2_mulrnd.sv
hdl/sr2_mix.sv
hdl/sr2_sat.sv
hdl/symmetric_2x2_rotation_apply.sv
dv/symmetric_2x2_rotation_apply_test.sv
